[hw/rtl/mmio_range_decoder_top_defines.svh]
// -----------------------------------------------------------------------------
// mmio_range_decoder_top_defines.svh
// Assertion macros shared by the range decoder checker.
// -----------------------------------------------------------------------------
`ifndef MMIO_RANGE_DECODER_TOP_DEFINES_SVH
`define MMIO_RANGE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MRD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mrd_pkg.sv]
// -----------------------------------------------------------------------------
// mrd_pkg
// Types and constants of the address range decoder.
// -----------------------------------------------------------------------------
package mrd_pkg;

	localparam int ADDR_W      = 32;
	localparam int DATA_W      = 64;
	localparam int SLOT_W      = 4;
	localparam int IN_TDATA_W  = 136;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 72;

	// input tdata field positions
	localparam int IN_ADDR_LO = 0;
	localparam int IN_EXT_LO  = 32;
	localparam int IN_RD_BIT  = 64;
	localparam int IN_WR_BIT  = 65;
	localparam int IN_DATA_LO = 66;

	// output tdata field positions
	localparam int OUT_OK_BIT  = 0;
	localparam int OUT_SLOT_LO = 1;
	localparam int OUT_RS_BIT  = 5;
	localparam int OUT_WS_BIT  = 6;
	localparam int OUT_FWD_LO  = 7;

	// legal access widths in bytes
	localparam logic [ADDR_W-1:0] WIDTH_1 = 32'd1;
	localparam logic [ADDR_W-1:0] WIDTH_2 = 32'd2;
	localparam logic [ADDR_W-1:0] WIDTH_4 = 32'd4;
	localparam logic [ADDR_W-1:0] WIDTH_8 = 32'd8;

	typedef enum logic [1:0] {
		ACT_REGISTER = 2'd0,
		ACT_READ     = 2'd1,
		ACT_WRITE    = 2'd2,
		ACT_CLEAR    = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} st_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] start;
	} ent_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture input item
		logic start;   // reset scan index and hit record
		logic issue;   // read table entry, advance index
		logic commit;  // write result, update table
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_needed;
		logic last_issue;
		logic out_free;
	} sts_t;

endpackage

[hw/rtl/mrd_ctrl.sv]
// -----------------------------------------------------------------------------
// mrd_ctrl
// Sequencer for capture, table scan and result commit.
// -----------------------------------------------------------------------------
module mrd_ctrl
	import mrd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.start = 1'b1;
				state_d   = sts.scan_needed ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last entry compared this cycle
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/mrd_datapath.sv]
// -----------------------------------------------------------------------------
// mrd_datapath
// Range table, entry compare, hit record and output register.
// -----------------------------------------------------------------------------
module mrd_datapath
	import mrd_pkg::*;
#(
	parameter int MAX_RANGES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  in_tdata,
	input  logic [IN_TUSER_W-1:0]  in_tuser,
	output logic                   out_tvalid,
	input  logic                   out_tready,
	output logic [OUT_TDATA_W-1:0] out_tdata,
	input  cmd_t                   cmd,
	output sts_t                   sts
);

	localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W = $clog2(MAX_RANGES + 1);

	// captured item
	act_t              act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] ext_q;
	logic              rd_q;
	logic              wr_q;
	logic [DATA_W-1:0] data_q;
	logic [ADDR_W:0]   stop_q;

	// table
	ent_t              mem [MAX_RANGES];
	logic [CNT_W-1:0]  count_q;

	// scan
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_s1;
	ent_t              ent_s1;
	logic              vld_s1;

	// first hit
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              hit_rd_q;
	logic              hit_wr_q;

	// output register
	logic              out_vld_q;
	logic              res_ok_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_rs_q;
	logic              res_ws_q;
	logic [DATA_W-1:0] res_fwd_q;

	logic              stop_fits;
	logic              width_ok;
	logic              pre_ok;
	logic [ADDR_W:0]   ent_end;
	logic              match;
	logic              reg_ok;

	logic              nx_ok;
	logic              nx_rs;
	logic              nx_ws;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= act_t'(in_tuser);
			addr_q <= in_tdata[IN_ADDR_LO +: ADDR_W];
			ext_q  <= in_tdata[IN_EXT_LO +: ADDR_W];
			rd_q   <= in_tdata[IN_RD_BIT];
			wr_q   <= in_tdata[IN_WR_BIT];
			data_q <= in_tdata[IN_DATA_LO +: DATA_W];
			stop_q <= {1'b0, in_tdata[IN_ADDR_LO +: ADDR_W]}
				+ {1'b0, in_tdata[IN_EXT_LO +: ADDR_W]};
		end
	end

	// end at or below 2^32
	assign stop_fits = !stop_q[ADDR_W] || (stop_q[ADDR_W-1:0] == '0);
	assign width_ok  = (ext_q == WIDTH_1) || (ext_q == WIDTH_2)
		|| (ext_q == WIDTH_4) || (ext_q == WIDTH_8);

	always_comb begin
		unique case (act_q)
			ACT_REGISTER: pre_ok = (ext_q != '0) && stop_fits
				&& (count_q < CNT_W'(MAX_RANGES));
			ACT_READ,
			ACT_WRITE:    pre_ok = width_ok && stop_fits;
			ACT_CLEAR:    pre_ok = 1'b1;
			default:      pre_ok = 1'b0;
		endcase
	end

	assign sts.scan_needed = (act_q != ACT_CLEAR) && pre_ok && (count_q != '0);
	assign sts.last_issue  = (CNT_W'(idx_q) == (count_q - 1'b1));
	assign sts.out_free    = !out_vld_q || out_tready;

	// table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.commit && (act_q == ACT_REGISTER) && reg_ok) begin
			mem[count_q[IDX_W-1:0]] <= '{wr: wr_q, rd: rd_q, len: ext_q, start: addr_q};
		end
		if (cmd.issue) begin
			ent_s1 <= mem[idx_q];
			idx_s1 <= idx_q;
		end
	end

	// entry compare, ends in 33 bits
	assign ent_end = {1'b0, ent_s1.start} + {1'b0, ent_s1.len};

	always_comb begin
		if (act_q == ACT_REGISTER) begin
			match = ({1'b0, addr_q} < ent_end) && ({1'b0, ent_s1.start} < stop_q);
		end else begin
			match = (addr_q >= ent_s1.start) && (stop_q <= ent_end);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.start) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (vld_s1 && match && !hit_q) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && match && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_rd_q  <= ent_s1.rd;
			hit_wr_q  <= ent_s1.wr;
		end
	end

	assign reg_ok = pre_ok && !hit_q;

	always_comb begin
		nx_ok = 1'b0;
		nx_rs = 1'b0;
		nx_ws = 1'b0;
		unique case (act_q)
			ACT_REGISTER: nx_ok = reg_ok;
			ACT_READ:     nx_rs = pre_ok && hit_q && hit_rd_q;
			ACT_WRITE:    nx_ws = pre_ok && hit_q && hit_wr_q;
			ACT_CLEAR:    nx_ok = 1'b1;
			default:      nx_ok = 1'b0;
		endcase
		if (nx_rs || nx_ws) begin
			nx_ok = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (out_tready) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.commit) begin
				if (act_q == ACT_CLEAR) begin
					count_q <= '0;
				end else if ((act_q == ACT_REGISTER) && reg_ok) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_ok_q   <= nx_ok;
			res_rs_q   <= nx_rs;
			res_ws_q   <= nx_ws;
			res_slot_q <= (nx_rs || nx_ws) ? SLOT_W'(hit_idx_q) : '0;
			res_fwd_q  <= nx_ws ? data_q : '0;
		end
	end

	assign out_tvalid = out_vld_q;
	assign out_tdata  = {1'b0, res_fwd_q, res_ws_q, res_rs_q, res_slot_q, res_ok_q};

endmodule

[hw/rtl/mmio_range_decoder_top.sv]
// -----------------------------------------------------------------------------
// mmio_range_decoder_top
// Address range table with bus access decode.
// -----------------------------------------------------------------------------
// Use: an item enters on the s_axis channel; tuser carries the action
// (register range, read, write, clear table), tdata the address, extent,
// handler flags and write data. Each item yields exactly one result item on
// m_axis: ok, slot, read/write strobe and forwarded write data.
// Timing: the table is held in a single-port memory read once per cycle,
// so a register, read or write item scans every stored range, one a cycle.
// An item steps through prepare, the scan, a drain step and finish, where
// the result is committed to the output register; the next item is accepted
// only after that. Clear, an empty table or an item refused on its own
// fields skips the scan and goes from prepare straight to finish.
// Stall: the result sits in an output register, so the next item is taken
// and worked on while m_axis is stalled; only the commit of that next result
// waits for the register to drain.
// Reset: arst_n empties the table, drops the result valid and leaves the
// input ready; table contents are not cleared and are never read before
// being written.
// -----------------------------------------------------------------------------
module mmio_range_decoder_top
	import mrd_pkg::*;
#(
	parameter int MAX_RANGES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input items
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// address[31:0], extent[63:32], has_reader[64], has_writer[65],
	// write_data[129:66], zero pad[135:130]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// action[1:0]
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	// result items
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// ok[0], slot[4:1], read_strobe[5], write_strobe[6],
	// forward_data[70:7], zero pad[71]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	mrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// table, compare and output register
	mrd_datapath #(
		.MAX_RANGES (MAX_RANGES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

[hw/rtl/mrd_checker.sv]
// -----------------------------------------------------------------------------
// mrd_checker
// Port-level checks of the range decoder, bound to the top level.
// -----------------------------------------------------------------------------
`include "mmio_range_decoder_top_defines.svh"

module mrd_checker
	import mrd_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [IN_TUSER_W-1:0]  s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic              ok;
	logic              rs;
	logic              ws;
	logic [SLOT_W-1:0] slot;
	logic [DATA_W-1:0] fwd;

	assign ok   = m_axis_tdata[OUT_OK_BIT];
	assign rs   = m_axis_tdata[OUT_RS_BIT];
	assign ws   = m_axis_tdata[OUT_WS_BIT];
	assign slot = m_axis_tdata[OUT_SLOT_LO +: SLOT_W];
	assign fwd  = m_axis_tdata[OUT_FWD_LO +: DATA_W];

	`MRD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
		"result dropped while stalled")
	`MRD_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"second item taken while one is in work")
	`MRD_ASSERT_IMPLY(a_strobe_excl, m_axis_tvalid, !(rs && ws),
		"read and write strobe together")
	`MRD_ASSERT_IMPLY(a_strobe_ok, m_axis_tvalid && (rs || ws), ok,
		"strobe without ok")
	`MRD_ASSERT_IMPLY(a_idle_zero, m_axis_tvalid && !ws, (fwd == '0) && (rs || slot == '0),
		"slot or data not zero without a decoded access")

endmodule

bind mmio_range_decoder_top mrd_checker u_mrd_checker (.*);

[dv/mmio_range_decoder_checker.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// mmio_range_decoder_checker
// Watches both streams of the range decoder, keeps its own copy of the range
// table, works out the result of every accepted item and compares it field by
// field with the result items that come out.
// -----------------------------------------------------------------------------
module mmio_range_decoder_checker
	import mrd_pkg::*;
#(
	parameter int MAX_RANGES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   run_done,
	output int                     fail_count,
	output int                     results_pending
);

	localparam logic [ADDR_W:0] TOP_OF_SPACE = 33'h1_0000_0000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		act_t              action;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] extent;
		logic              has_reader;
		logic              has_writer;
		logic [DATA_W-1:0] write_data;
	} bus_item_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] slot;
		logic              read_strobe;
		logic              write_strobe;
		logic [DATA_W-1:0] forward_data;
		logic              pad;
	} decode_t;

	// shadow range table
	logic [ADDR_W-1:0] map_base [MAX_RANGES];
	logic [ADDR_W-1:0] map_len  [MAX_RANGES];
	logic              map_rd   [MAX_RANGES];
	logic              map_wr   [MAX_RANGES];
	int                map_used;

	decode_t expected_q[$];
	int      mismatches = 0;
	int      backlog    = 0;
	logic    leftover_flagged;

	assign fail_count      = mismatches;
	assign results_pending = backlog;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns decode mismatch: %s", $time, what);
	endtask

	// Result of one item; register and clear also update the shadow table.
	function automatic decode_t decode_item(input bus_item_t it);
		decode_t         r;
		logic [ADDR_W:0] stop;
		logic [ADDR_W:0] map_end;
		logic            width_legal;
		int              hit;
		int              i;
		r    = '0;
		hit  = -1;
		stop = {1'b0, it.address} + {1'b0, it.extent};
		case (it.action)
			ACT_REGISTER: begin
				r.ok = (it.extent != '0) && (stop <= TOP_OF_SPACE) && (map_used < MAX_RANGES);
				for (i = 0; i < map_used; i++) begin
					map_end = {1'b0, map_base[i]} + {1'b0, map_len[i]};
					if ({1'b0, it.address} < map_end && {1'b0, map_base[i]} < stop)
						r.ok = 1'b0;
				end
				if (r.ok) begin
					map_base[map_used] = it.address;
					map_len[map_used]  = it.extent;
					map_rd[map_used]   = it.has_reader;
					map_wr[map_used]   = it.has_writer;
					map_used++;
				end
			end
			ACT_CLEAR: begin
				map_used = 0;
				r.ok     = 1'b1;
			end
			default: begin
				width_legal = it.extent == WIDTH_1 || it.extent == WIDTH_2 ||
					it.extent == WIDTH_4 || it.extent == WIDTH_8;
				if (width_legal && stop <= TOP_OF_SPACE) begin
					// first stored range wholly holding the access wins
					for (i = 0; i < map_used; i++) begin
						map_end = {1'b0, map_base[i]} + {1'b0, map_len[i]};
						if (hit < 0 && it.address >= map_base[i] && stop <= map_end)
							hit = i;
					end
				end
				if (hit >= 0) begin
					if (it.action == ACT_READ && map_rd[hit]) begin
						r.ok          = 1'b1;
						r.read_strobe = 1'b1;
						r.slot        = hit[SLOT_W-1:0];
					end else if (it.action == ACT_WRITE && map_wr[hit]) begin
						r.ok           = 1'b1;
						r.write_strobe = 1'b1;
						r.slot         = hit[SLOT_W-1:0];
						r.forward_data = it.write_data;
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_item_t item;
		decode_t   want;
		decode_t   got;
		if (!arst_n) begin
			map_used = 0;
			expected_q.delete();
			leftover_flagged = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.ok           = m_axis_tdata[OUT_OK_BIT];
				got.slot         = m_axis_tdata[OUT_SLOT_LO +: SLOT_W];
				got.read_strobe  = m_axis_tdata[OUT_RS_BIT];
				got.write_strobe = m_axis_tdata[OUT_WS_BIT];
				got.forward_data = m_axis_tdata[OUT_FWD_LO +: DATA_W];
				got.pad          = m_axis_tdata[OUT_TDATA_W-1];
				if (expected_q.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					want = expected_q.pop_front();
					if (got.ok !== want.ok)
						report_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
					if (got.slot !== want.slot)
						report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
					if (got.read_strobe !== want.read_strobe)
						report_mismatch($sformatf("read_strobe %b, want %b",
							got.read_strobe, want.read_strobe));
					if (got.write_strobe !== want.write_strobe)
						report_mismatch($sformatf("write_strobe %b, want %b",
							got.write_strobe, want.write_strobe));
					if (got.forward_data !== want.forward_data)
						report_mismatch($sformatf("forward_data %h, want %h",
							got.forward_data, want.forward_data));
					if (got.pad !== want.pad)
						report_mismatch($sformatf("pad bit %b, want 0", got.pad));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				item.action     = act_t'(s_axis_tuser);
				item.address    = s_axis_tdata[IN_ADDR_LO +: ADDR_W];
				item.extent     = s_axis_tdata[IN_EXT_LO +: ADDR_W];
				item.has_reader = s_axis_tdata[IN_RD_BIT];
				item.has_writer = s_axis_tdata[IN_WR_BIT];
				item.write_data = s_axis_tdata[IN_DATA_LO +: DATA_W];
				expected_q.insert(expected_q.size(), decode_item(item));
			end
			if (run_done && !leftover_flagged && expected_q.size() != 0) begin
				leftover_flagged = 1'b1;
				report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
			end
		end
		backlog = expected_q.size();
	end

endmodule

[dv/mmio_range_decoder_top_test.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// mmio_range_decoder_top_test
// Drives register, read, write and clear items into the range decoder and
// gives the verdict. A short directed list covers the table edges and the
// refusals but a full table; random sequences then build tables and hammer
// them with accesses, under four idling patterns and one long output hold-off.
// All checking is in the checkers beside the block.
// -----------------------------------------------------------------------------
module mmio_range_decoder_top_test;
	import mrd_pkg::*;

	localparam int     MAX_RANGES    = 16;
	localparam int     RANDOM_ITEMS  = 815;
	localparam int     HOLD_CYCLES   = 300;   // long output hold-off
	localparam int     SETTLE_CYCLES = 40;    // room for a full-table scan
	localparam int     DRAIN_LIMIT   = 20000;
	localparam longint RUN_LIMIT_NS  = 64'd5_000_000;
	localparam int     KNOWN_MAX     = 20;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_active    = 1'b0;
	event hold_go;
	logic run_done       = 1'b0;
	int   items_sent     = 0;
	int   fail_count;
	int   results_pending;

	mmio_range_decoder_top #(
		.MAX_RANGES(MAX_RANGES)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	mmio_range_decoder_checker #(
		.MAX_RANGES(MAX_RANGES)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.run_done       (run_done),
		.fail_count     (fail_count),
		.results_pending(results_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Output side: random stalls at the current rate, forced low during reset or a hold-off.
	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n || hold_active)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	// Hold-off counter, in its own process so the sender keeps going meanwhile.
	initial begin
		forever begin
			@(hold_go);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Offer one item, with random idle cycles ahead of it; returns in the time
	// step of the accepting edge, so the caller may drive the next item at once.
	task automatic offer_item(input act_t act, input logic [ADDR_W-1:0] addr,
		input logic [ADDR_W-1:0] ext, input logic rd, input logic wr,
		input logic [DATA_W-1:0] data);
		logic [IN_TDATA_W-1:0] payload;
		payload = '0;
		payload[IN_ADDR_LO +: ADDR_W] = addr;
		payload[IN_EXT_LO +: ADDR_W]  = ext;
		payload[IN_RD_BIT]            = rd;
		payload[IN_WR_BIT]            = wr;
		payload[IN_DATA_LO +: DATA_W] = data;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= payload;
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// One random sequence: maybe clear, lay out a run of ranges (mostly
	// disjoint, some overlapping, some zero-length or past the top), then
	// aim accesses at them with the odd bad width, straddle and noise item.
	task automatic run_sequence();
		logic [ADDR_W-1:0] known_base [KNOWN_MAX];
		logic [ADDR_W-1:0] known_len  [KNOWN_MAX];
		logic [ADDR_W-1:0] cursor;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] width;
		logic [ADDR_W-1:0] addr;
		int                n_known;
		int                n_ranges;
		int                n_access;
		int                i;
		int                k;
		if ($urandom_range(0, 3) != 0)
			offer_item(ACT_CLEAR, $urandom, $urandom, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), {$urandom, $urandom});
		// now and then try to overfill the table
		n_ranges = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
		case ($urandom_range(0, 3))
			0: cursor = '0;
			1: cursor = 32'hFFFF_FFFF - $urandom_range(0, 4095);
			default: cursor = $urandom;
		endcase
		n_known = 0;
		for (i = 0; i < n_ranges; i++) begin
			case ($urandom_range(0, 9))
				0: len = $urandom;
				1: len = '0;
				2, 3, 4: len = 32'd1 << $urandom_range(0, 6);
				default: len = $urandom_range(1, 300);
			endcase
			if (n_known > 0 && $urandom_range(0, 7) == 0)
				base = known_base[n_known-1] + $urandom_range(0, 8);
			else
				base = cursor + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 64));
			cursor = base + len;
			if (n_known < KNOWN_MAX) begin
				known_base[n_known] = base;
				known_len[n_known]  = len;
				n_known++;
			end
			offer_item(ACT_REGISTER, base, len, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), {$urandom, $urandom});
		end
		n_access = $urandom_range(4, 24);
		for (i = 0; i < n_access; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				offer_item(act_t'($urandom_range(0, 3)), $urandom, $urandom,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), {$urandom, $urandom});
			end else begin
				k = $urandom_range(0, n_known - 1);
				case ($urandom_range(0, 11))
					0: width = $urandom;
					1: width = $urandom_range(0, 16);
					default: width = 32'd1 << $urandom_range(0, 3);
				endcase
				case ($urandom_range(0, 3))
					0: addr = known_base[k];
					1: addr = known_base[k] + known_len[k] - width;
					2: addr = known_base[k] +
						((known_len[k] == 0) ? 0 : ($urandom % known_len[k]));
					default: addr = known_base[k] - $urandom_range(1, 4);
				endcase
				offer_item($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, addr, width,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), {$urandom, $urandom});
			end
		end
	endtask

	initial begin
		int first_random;
		int drain_cycles;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: table edges, refusals but a full table, every action
		offer_item(ACT_READ,     32'h0000_0000, WIDTH_1,       1'b0, 1'b0, '0);  // empty table
		offer_item(ACT_REGISTER, 32'h0000_0100, 32'h0,         1'b1, 1'b1, '0);  // zero length
		offer_item(ACT_REGISTER, 32'hFFFF_FF00, 32'h101,       1'b1, 1'b1, '0);  // past the top
		offer_item(ACT_REGISTER, 32'hFFFF_FFF8, 32'h8,         1'b1, 1'b1, '0);  // ends at 2^32
		offer_item(ACT_REGISTER, 32'h0000_1000, 32'h100,       1'b1, 1'b0, '0);  // read only
		offer_item(ACT_REGISTER, 32'h0000_10FC, 32'h8,         1'b1, 1'b1, '0);  // overlap
		offer_item(ACT_REGISTER, 32'h0000_0FF8, 32'h8,         1'b0, 1'b1, '0);  // abutting, write only
		offer_item(ACT_READ,     32'h0000_1000, WIDTH_8,       1'b0, 1'b0, '0);
		offer_item(ACT_WRITE,    32'h0000_10F8, WIDTH_8,       1'b0, 1'b0, '1);  // no writer
		offer_item(ACT_WRITE,    32'h0000_0FFC, WIDTH_4,       1'b1, 1'b0, '1);  // flags ignored
		offer_item(ACT_READ,     32'h0000_0FFC, WIDTH_4,       1'b1, 1'b1, '0);  // no reader
		offer_item(ACT_READ,     32'h0000_0FFE, WIDTH_4,       1'b0, 1'b0, '0);  // straddles two
		offer_item(ACT_READ,     32'hFFFF_FFF8, WIDTH_8,       1'b0, 1'b0, '0);
		offer_item(ACT_WRITE,    32'hFFFF_FFFF, WIDTH_1,       1'b0, 1'b0,
			64'h0123_4567_89AB_CDEF);
		offer_item(ACT_READ,     32'hFFFF_FFFC, WIDTH_8,       1'b0, 1'b0, '0);  // access past top
		offer_item(ACT_READ,     32'h0000_1000, 32'h3,         1'b0, 1'b0, '0);  // bad width
		offer_item(ACT_READ,     32'h0000_1000, 32'h8000_0004, 1'b0, 1'b0, '0);  // high bits set
		offer_item(ACT_READ,     32'h0000_1000, 32'h0,         1'b0, 1'b0, '0);
		offer_item(ACT_CLEAR,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '1);
		offer_item(ACT_READ,     32'h0000_1000, WIDTH_1,       1'b0, 1'b0, '0);  // gone after clear
		offer_item(ACT_REGISTER, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, '0);  // widest range
		offer_item(ACT_WRITE,    32'hFFFF_FFF7, WIDTH_8,       1'b0, 1'b0, '0);
		offer_item(ACT_REGISTER, 32'hFFFF_FFFF, 32'h1,         1'b1, 1'b0, '0);  // last byte
		offer_item(ACT_READ,     32'hFFFF_FFFF, WIDTH_1,       1'b0, 1'b0, '0);
		offer_item(ACT_CLEAR,    32'h0,         32'h0,         1'b0, 1'b0, '0);

		// random part; the hold-off lands in the no-idling phase so the
		// block backs up and stalls its input
		first_random = items_sent;
		-> hold_go;
		while (items_sent < first_random + RANDOM_ITEMS) begin
			case ((items_sent - first_random) * 4 / RANDOM_ITEMS)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 54;
				end
				default: begin
					send_idle_pct  = 6;
					recv_stall_pct = 6;
				end
			endcase
			run_sequence();
		end
		s_axis_tvalid <= 1'b0;

		// let the outstanding results drain, then allow a full scan's worth
		drain_cycles = 0;
		while (results_pending != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(negedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		run_done <= 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mrd_pkg.sv
hw/rtl/mrd_ctrl.sv
hw/rtl/mrd_datapath.sv
hw/rtl/mmio_range_decoder_top.sv
hw/rtl/mrd_checker.sv
dv/mmio_range_decoder_checker.sv
dv/mmio_range_decoder_top_test.sv
